FILE: rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int ITEM_W = 32;

    typedef logic signed [ITEM_W-1:0] item_t;

    // Request codes on s_operation
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PUSH_REAR  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } op_code_t;

    // Result status codes on m_status
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast along the cell chain
    typedef enum logic [2:0] {
        CH_HOLD,
        CH_SHR,
        CH_SHL,
        CH_ROT,
        CH_PUSHR
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        item_t     item;
    } chain_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_POP_REAR,
        S_LIST
    } seq_state_t;

endpackage

FILE: rtl/bounded_deque.sv
// bounded_deque: a double-ended queue of up to DEPTH signed 32-bit items, held
// in a row of identical cells. Cell 0 always holds the front item and the held
// items occupy cells 0 to count-1 in order; each cell carries an occupied bit.
// Every cycle a single command is broadcast along the row and each cell takes
// its value from itself, a neighbor, the new item or the head: shift right
// (push front), shift left (pop front), write at the first empty cell (push
// rear) or rotate the held run left by one (the head moves to the rear).
// Requests arrive on the s_ channel (s_operation, s_item_value) and results
// leave on the m_ channel (m_result_value, m_status, m_last_of_run) through a
// one-entry output register, each transfer on valid and ready. Push front,
// push rear and pop front finish in the request cycle, as does pop rear with
// a single item held. Pop rear with more than one item held first rotates the
// run count-1 times to bring the rear item into cell 0, then pops it, leaving
// the rest in order. List emits cell 0 and rotates once for each held item,
// so after count rotations the queue is back in its original order; the last
// result carries m_last_of_run. A result waiting unread with m_ready low
// stalls a pop rear or list still emitting. A push onto a full queue returns
// status full and changes nothing; a pop or list of an empty queue returns
// status empty. Codes 5 to 7 are taken and produce no result. No new request
// is taken while a pop rear or list is running or while a result waits
// unread with m_ready low.
module bounded_deque #(
    parameter int DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic signed [31:0]  s_item_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_result_value,
    output logic [1:0]          m_status,
    output logic                m_last_of_run
);
    import bdq_pkg::*;

    chain_cmd_t cmd;
    item_t      head_val;
    item_t      cell_val  [DEPTH];
    logic       cell_occ  [DEPTH];
    item_t      left_val  [DEPTH];
    logic       left_occ  [DEPTH];
    item_t      right_val [DEPTH];
    logic       right_occ [DEPTH];

    assign head_val = cell_val[0];

    // sequencer: decodes requests, tracks the count, drives the chain
    bdq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_value(m_result_value),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run),
        .head_val      (head_val),
        .cmd           (cmd)
    );

    // row of cells; cell 0 sees the new item on its left, the last cell sees
    // an empty neighbor on its right
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign left_val[k] = cmd.item;
            assign left_occ[k] = 1'b1;
        end else begin : g_mid_left
            assign left_val[k] = cell_val[k-1];
            assign left_occ[k] = cell_occ[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_val[k] = '0;
            assign right_occ[k] = 1'b0;
        end else begin : g_mid_right
            assign right_val[k] = cell_val[k+1];
            assign right_occ[k] = cell_occ[k+1];
        end

        bdq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .head_val (head_val),
            .left_val (left_val[k]),
            .left_occ (left_occ[k]),
            .right_val(right_val[k]),
            .right_occ(right_occ[k]),
            .val      (cell_val[k]),
            .occ      (cell_occ[k])
        );
    end

endmodule

FILE: rtl/bdq_cell.sv
module bdq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  bdq_pkg::chain_cmd_t cmd,
    input  bdq_pkg::item_t     head_val,
    input  bdq_pkg::item_t     left_val,
    input  logic               left_occ,
    input  bdq_pkg::item_t     right_val,
    input  logic               right_occ,
    output bdq_pkg::item_t     val,
    output logic               occ
);
    import bdq_pkg::*;

    item_t val_reg;
    item_t val_next;
    logic  occ_reg;
    logic  occ_next;

    always_comb begin
        val_next = val_reg;
        occ_next = occ_reg;
        unique case (cmd.op)
            CH_HOLD: begin
            end
            CH_SHR: begin
                val_next = left_val;
                occ_next = left_occ;
            end
            CH_SHL: begin
                val_next = right_val;
                occ_next = right_occ;
            end
            CH_ROT: begin
                // last held cell takes the head, others take their right neighbor
                if (occ_reg && !right_occ) begin
                    val_next = head_val;
                end else if (occ_reg) begin
                    val_next = right_val;
                end
            end
            CH_PUSHR: begin
                if (!occ_reg && left_occ) begin
                    val_next = cmd.item;
                    occ_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign occ = occ_reg;

endmodule

FILE: rtl/bdq_ctrl.sv
module bdq_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  bdq_pkg::item_t      s_item_value,
    output logic                m_valid,
    input  logic                m_ready,
    output bdq_pkg::item_t      m_result_value,
    output logic [1:0]          m_status,
    output logic                m_last_of_run,
    input  bdq_pkg::item_t      head_val,
    output bdq_pkg::chain_cmd_t cmd
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    seq_state_t    state_reg;
    seq_state_t    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;

    logic          m_valid_reg;
    item_t         m_value_reg;
    status_t       m_status_reg;
    logic          m_last_reg;

    logic          slot_free;
    logic          accept;
    logic          is_empty;
    logic          is_full;
    logic          is_single;
    op_code_t      op;

    logic          emit;
    item_t         emit_value;
    status_t       emit_status;
    logic          emit_last;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_single = (count_reg == CW'(1));
    assign op        = op_code_t'(s_operation);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_POP_REAR && !is_empty && !is_single) begin
                        state_next = S_ROTATE;
                    end else if (op == OP_LIST && !is_empty) begin
                        state_next = S_LIST;
                    end
                end
            end
            S_ROTATE: begin
                if (rem_reg == CW'(1)) begin
                    state_next = S_POP_REAR;
                end
            end
            S_POP_REAR: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            S_LIST: begin
                if (slot_free && rem_reg == CW'(1)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // chain command, counters and result
    always_comb begin
        cmd.op      = CH_HOLD;
        cmd.item    = s_item_value;
        count_next  = count_reg;
        rem_next    = rem_reg;
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = STAT_OK;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            emit = 1'b1;
                            if (is_full) begin
                                emit_status = STAT_FULL;
                            end else begin
                                cmd.op     = (op == OP_PUSH_FRONT) ? CH_SHR : CH_PUSHR;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_status = STAT_EMPTY;
                            end else begin
                                emit_value = head_val;
                                cmd.op     = CH_SHL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_REAR: begin
                            if (is_empty) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else if (is_single) begin
                                emit       = 1'b1;
                                emit_value = head_val;
                                cmd.op     = CH_SHL;
                                count_next = count_reg - CW'(1);
                            end else begin
                                rem_next = count_reg - CW'(1);
                            end
                        end
                        OP_LIST: begin
                            if (is_empty) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else begin
                                rem_next = count_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ROTATE: begin
                cmd.op   = CH_ROT;
                rem_next = rem_reg - CW'(1);
            end
            S_POP_REAR: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_value = head_val;
                    cmd.op     = CH_SHL;
                    count_next = count_reg - CW'(1);
                end
            end
            S_LIST: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_value = head_val;
                    emit_last  = (rem_reg == CW'(1));
                    cmd.op     = CH_ROT;
                    rem_next   = rem_reg - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_value_reg  <= emit_value;
            m_status_reg <= emit_status;
            m_last_reg   <= emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_last_of_run  = m_last_reg;

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input taken while a multi-cycle request is running");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("held count above depth");

    a_list_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (rem_reg != '0 && rem_reg <= count_reg))
        else $error("listing counter out of range");

    a_rotate_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROTATE) |-> (rem_reg != '0 && rem_reg < count_reg))
        else $error("rotation counter out of range");

    a_full_push_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR))
        |=> $stable(count_reg))
        else $error("push onto full queue changed the count");
`endif

endmodule
